// File: rtl/cbm_pkg.sv
// Shared types, constants and field layout for the cartridge bank mapper.
// No dependencies; used by every module of the block.
package cbm_pkg;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int MAX_ROM_BANKS  = 128;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int RAM_BANKS      = 4;

  localparam int ROM_OFF_W   = $clog2(ROM_BANK_BYTES);
  localparam int ROM_BANK_W  = $clog2(MAX_ROM_BANKS);
  localparam int ROM_ADDR_W  = 21;
  localparam int RAM_OFF_W   = $clog2(RAM_BANK_BYTES);
  localparam int RAM_BANK_W  = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
  localparam int RAM_ADDR_W  = $clog2(RAM_BANKS * RAM_BANK_BYTES);
  localparam int RAM_DEPTH   = RAM_BANKS * RAM_BANK_BYTES;

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_PRESENT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_MASK = 2'd2;

  // Address regions selected by address[15:13]
  localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
  localparam logic [2:0] REGION_ROM_BANK   = 3'd1;
  localparam logic [2:0] REGION_UPPER_BANK = 3'd2;
  localparam logic [2:0] REGION_MODE       = 3'd3;
  localparam logic [2:0] REGION_EXT_RAM    = 3'd5;

  localparam logic [3:0]        RAM_ENABLE_KEY = 4'hA;
  localparam logic [DATA_W-1:0] OPEN_BUS       = 8'hFF;
  localparam logic [DATA_W-1:0] MODE_SIMPLE    = 8'h00;
  localparam logic [DATA_W-1:0] MODE_ADVANCED  = 8'h01;

  typedef enum logic [1:0] {
    KIND_ROM   = 2'd0,
    KIND_RAM   = 2'd1,
    KIND_OPEN  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [ROM_ADDR_W-1:0]  rom_address;
    logic [DATA_W-1:0]      fixed_data;
    logic                   ram_rd;
    logic                   ram_wr;
    logic [RAM_ADDR_W-1:0]  ram_addr;
    logic [DATA_W-1:0]      ram_wdata;
  } access_t;

endpackage

// File: rtl/cartridge_bank_mapper_core.sv
// Cartridge bank mapper top level: bus access in, ROM address or RAM data out.
// An accepted access passes the RAM read stage, then the result register, to result valid.
// Throughput: one item per cycle while m_tready allows; a single RAM port serves each access.
// Reset: synchronous, resets bank and config registers and pipeline valids; RAM is not cleared.
// Depends on cbm_pkg, cbm_regs and cbm_ram.
module cartridge_bank_mapper_core
  import cbm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // address[15:0], write_data[23:16]
  input  logic                   s_tuser,   // func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // rom_address[20:0], read_data[28:21], zero
  output logic [1:0]             m_tuser    // result_kind
);

  access_t           access;
  logic              accept;
  logic              b_valid;
  logic              b_advance;
  kind_t             b_kind;
  logic [ROM_ADDR_W-1:0] b_rom_address;
  logic [DATA_W-1:0] b_fixed_data;
  logic              b_ram;
  logic [DATA_W-1:0] ram_rdata;
  kind_t             out_kind;
  logic [ROM_ADDR_W-1:0] out_rom_address;
  logic [DATA_W-1:0] out_read_data;

  assign b_advance = b_valid && (!m_tvalid || m_tready);
  assign s_tready  = !b_valid || b_advance;
  assign accept    = s_tvalid && s_tready;

  cbm_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .func       (s_tuser),
    .address    (s_tdata[ADDR_W-1:0]),
    .write_data (s_tdata[ADDR_W+DATA_W-1:ADDR_W]),
    .access     (access)
  );

  cbm_ram u_ram (
    .clk   (clk),
    .we    (accept && access.ram_wr),
    .re    (accept && access.ram_rd),
    .addr  (access.ram_addr),
    .wdata (access.ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_advance) begin
        b_valid <= 1'b0;
      end
      if (b_advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_kind        <= access.kind;
      b_rom_address <= access.rom_address;
      b_fixed_data  <= access.fixed_data;
      b_ram         <= access.ram_rd;
    end
    if (b_advance) begin
      out_kind        <= b_kind;
      out_rom_address <= b_rom_address;
      out_read_data   <= b_ram ? ram_rdata : b_fixed_data;
    end
  end

  assign m_tdata = OUT_TDATA_W'({out_read_data, out_rom_address});
  assign m_tuser = out_kind;

endmodule

// File: rtl/cbm_ram.sv
// External cartridge RAM: one access per cycle, registered read data.
// Depends on cbm_pkg for depth and widths.
module cbm_ram
  import cbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic                  re,
  input  logic [RAM_ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0]     wdata,
  output logic [DATA_W-1:0]     rdata
);

  logic [DATA_W-1:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/cbm_regs.sv
// Configuration and bank registers, access decode and address translation.
// Depends on cbm_pkg; feeds the RAM port and the result pipeline.
module cbm_regs
  import cbm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   accept,
  input  logic                   func,
  input  logic [ADDR_W-1:0]      address,
  input  logic [DATA_W-1:0]      write_data,
  output access_t                access
);

  logic [ROM_BANK_W-1:0] rom_bank_mask;
  logic                  ram_present;
  logic [1:0]            ram_bank_mask;
  logic                  ram_enabled;
  logic [4:0]            low_rom_bank;
  logic [1:0]            upper_bank;
  logic                  advanced_mode;

  logic [2:0]            region;
  logic                  ram_ok;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [RAM_BANK_W-1:0] ram_bank;

  assign region = address[ADDR_W-1:ADDR_W-3];
  assign ram_ok = ram_present && ram_enabled && (region == REGION_EXT_RAM);

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_mask <= ROM_BANK_W'(1);
      ram_present   <= 1'b0;
      ram_bank_mask <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_BANK_MASK: rom_bank_mask <= cfg_data[ROM_BANK_W-1:0];
        CFG_RAM_PRESENT:   ram_present   <= cfg_data[0];
        CFG_RAM_BANK_MASK: ram_bank_mask <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled   <= 1'b0;
      low_rom_bank  <= 5'd1;
      upper_bank    <= 2'd0;
      advanced_mode <= 1'b0;
    end else if (accept && func) begin
      case (region)
        REGION_RAM_ENABLE: ram_enabled <= (write_data[3:0] == RAM_ENABLE_KEY);
        REGION_ROM_BANK:   low_rom_bank <= (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];
        REGION_UPPER_BANK: upper_bank <= write_data[1:0];
        REGION_MODE: begin
          if (write_data == MODE_SIMPLE) begin
            advanced_mode <= 1'b0;
          end else if (write_data == MODE_ADVANCED) begin
            advanced_mode <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!address[ROM_OFF_W]) begin
      rom_bank = advanced_mode ? (ROM_BANK_W'({upper_bank, 5'd0}) & rom_bank_mask)
                               : '0;
    end else begin
      rom_bank = ROM_BANK_W'({upper_bank, low_rom_bank}) & rom_bank_mask;
    end
    ram_bank = advanced_mode ? RAM_BANK_W'(upper_bank & ram_bank_mask) : '0;
  end

  always_comb begin
    access.rom_address = '0;
    access.fixed_data  = '0;
    access.ram_rd      = 1'b0;
    access.ram_wr      = 1'b0;
    access.ram_addr    = RAM_ADDR_W'({ram_bank, address[RAM_OFF_W-1:0]});
    access.ram_wdata   = write_data;
    if (func) begin
      access.kind   = KIND_WRITE;
      access.ram_wr = ram_ok;
    end else if (!address[ADDR_W-1]) begin
      access.kind        = KIND_ROM;
      access.rom_address = ROM_ADDR_W'({rom_bank, address[ROM_OFF_W-1:0]});
    end else if (ram_ok) begin
      access.kind   = KIND_RAM;
      access.ram_rd = 1'b1;
    end else begin
      access.kind       = KIND_OPEN;
      access.fixed_data = OPEN_BUS;
    end
  end

endmodule

// File: rtl/cbm_checker.sv
// Port-level checker for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg for result kinds and field layout.
module cbm_checker
  import cbm_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]             m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_WRITE) |-> (m_tdata == '0))
    else $error("write result carries data");

  a_rom_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ROM) |-> (m_tdata[ROM_ADDR_W+DATA_W-1:ROM_ADDR_W] == '0))
    else $error("rom result carries read data");

  a_open_bus: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_OPEN) |->
      (m_tdata[ROM_ADDR_W+DATA_W-1:ROM_ADDR_W] == OPEN_BUS) &&
      (m_tdata[ROM_ADDR_W-1:0] == '0))
    else $error("open bus result malformed");

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: bench/tb_cartridge_bank_mapper_core.sv
// Self-checking bench for cartridge_bank_mapper_core: bus accesses in, one result out each.
// Runs a directed table, then random accesses under several register settings. Depends on
// cbm_pkg and the RTL. Results are checked against table values or the in-bench predictor.
module tb_cartridge_bank_mapper_core
  import cbm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit FUNC_READ    = 1'b0;
  localparam bit FUNC_WRITE   = 1'b1;
  localparam int DRAIN_CYCLES = 4;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 170;

  typedef struct packed {
    kind_t                 kind;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [DATA_W-1:0]     read_data;
  } cart_result_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    bit                     wr;
    logic [ADDR_W-1:0]      addr;
    logic [DATA_W-1:0]      data;
    bit                     typed;
    cart_result_t           want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // address[15:0], write_data[23:16]
  logic                   s_tuser = 1'b0; // func
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // rom_address[20:0], read_data[28:21], zero
  logic [1:0]             m_tuser;        // result_kind

  // predictor state
  logic [6:0]        cfg_rom_mask = 7'd1;
  logic              cfg_ram_present = 1'b0;
  logic [1:0]        cfg_ram_mask = 2'd0;
  logic              st_ram_on = 1'b0;
  logic [4:0]        st_low_bank = 5'd1;
  logic [1:0]        st_upper = 2'd0;
  logic              st_adv = 1'b0;
  logic [DATA_W-1:0] ram_image [RAM_DEPTH];
  bit                ram_written [RAM_DEPTH];

  cart_result_t expected_q[$];
  plan_row_t    plan[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int settings_used = 1;
  int quiet_cycles = 0;
  int kind_seen [4] = '{0, 0, 0, 0};

  cartridge_bank_mapper_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit in_ram_window(logic [ADDR_W-1:0] a);
    return a >= 16'hA000 && a <= 16'hBFFF;
  endfunction

  function automatic logic [RAM_ADDR_W-1:0] ram_slot(logic [ADDR_W-1:0] a);
    logic [RAM_BANK_W-1:0] bank;
    bank = st_adv ? (st_upper & cfg_ram_mask) : '0;
    return {bank, a[RAM_OFF_W-1:0]};
  endfunction

  function automatic cart_result_t map_access(bit wr, logic [ADDR_W-1:0] a,
                                              logic [DATA_W-1:0] d);
    cart_result_t r;
    logic [ROM_BANK_W-1:0] bank;
    bit ram_ok;
    r = '{KIND_WRITE, '0, '0};
    ram_ok = cfg_ram_present && st_ram_on;
    if (wr == FUNC_WRITE) begin
      if (a <= 16'h1FFF) begin
        st_ram_on = (d[3:0] == RAM_ENABLE_KEY);
      end else if (a <= 16'h3FFF) begin
        st_low_bank = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
      end else if (a <= 16'h5FFF) begin
        st_upper = d[1:0];
      end else if (a <= 16'h7FFF) begin
        if (d == MODE_SIMPLE) st_adv = 1'b0;
        else if (d == MODE_ADVANCED) st_adv = 1'b1;
      end else if (in_ram_window(a) && ram_ok) begin
        ram_image[ram_slot(a)] = d;
        ram_written[ram_slot(a)] = 1'b1;
      end
    end else if (a <= 16'h7FFF) begin
      if (a <= 16'h3FFF) bank = st_adv ? ({st_upper, 5'd0} & cfg_rom_mask) : '0;
      else bank = {st_upper, st_low_bank} & cfg_rom_mask;
      r.kind = KIND_ROM;
      r.rom_address = {bank, a[ROM_OFF_W-1:0]};
    end else if (in_ram_window(a) && ram_ok) begin
      r.kind = KIND_RAM;
      r.read_data = ram_image[ram_slot(a)];
    end else begin
      r.kind = KIND_OPEN;
      r.read_data = OPEN_BUS;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_ram_addr();
    if ($urandom_range(0, 1)) return 16'hA000 | 16'($urandom_range(0, 7));
    return 16'hA000 | 16'($urandom_range(0, 16'h1FFF));
  endfunction

  task automatic make_random_access(output bit wr, output logic [ADDR_W-1:0] a,
                                    output logic [DATA_W-1:0] d);
    int pick;
    pick = $urandom_range(0, 99);
    d = 8'($urandom_range(0, 255));
    if (pick < 15) begin
      wr = FUNC_WRITE;
      a = 16'($urandom_range(0, 16'h7FFF));
      case (a[15:13])
        REGION_RAM_ENABLE: if ($urandom_range(0, 1)) d = {d[7:4], RAM_ENABLE_KEY};
        REGION_MODE: if ($urandom_range(0, 3) != 0) d = 8'($urandom_range(0, 1));
        default: ;
      endcase
    end else if (pick < 40) begin
      wr = FUNC_WRITE;
      a = pick_ram_addr();
    end else if (pick < 60) begin
      wr = FUNC_READ;
      a = pick_ram_addr();
    end else if (pick < 90) begin
      wr = FUNC_READ;
      a = 16'($urandom_range(0, 16'h7FFF));
    end else begin
      wr = 1'($urandom_range(0, 1));
      a = 16'($urandom_range(0, 16'hFFFF));
    end
    // turn a read of a never-written RAM byte into a write
    if (wr == FUNC_READ && in_ram_window(a) && cfg_ram_present && st_ram_on &&
        !ram_written[ram_slot(a)])
      wr = FUNC_WRITE;
  endtask

  task automatic send_access(input bit wr, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d, input bit typed,
                             input cart_result_t want);
    cart_result_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {d, a};
    s_tuser  <= wr;
    do @(posedge clk); while (!s_tready);
    r = map_access(wr, a, d);
    expected_q.push_back(typed ? want : r);
    items_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROM_BANK_MASK: cfg_rom_mask = val[6:0];
      CFG_RAM_PRESENT:   cfg_ram_present = val[0];
      CFG_RAM_BANK_MASK: cfg_ram_mask = val[1:0];
      default: ;
    endcase
  endtask

  task automatic plan_io(input bit wr, input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    plan.push_back('{1'b0, '0, '0, wr, a, d, 1'b0, '0});
  endtask

  task automatic plan_chk(input bit wr, input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
                          input kind_t k, input logic [ROM_ADDR_W-1:0] ra,
                          input logic [DATA_W-1:0] rd);
    plan.push_back('{1'b0, '0, '0, wr, a, d, 1'b1, '{k, ra, rd}});
  endtask

  task automatic plan_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    plan.push_back('{1'b1, idx, val, 1'b0, '0, '0, 1'b0, '0});
  endtask

  always @(posedge clk) begin
    cart_result_t want;
    cart_result_t got;
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.kind        = kind_t'(m_tuser);
        got.rom_address = m_tdata[20:0];
        got.read_data   = m_tdata[28:21];
        kind_seen[m_tuser]++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: kind %0d rom %06h data %02h",
                   $time, got.kind, got.rom_address, got.read_data);
        end else begin
          want = expected_q.pop_front();
          if (got.kind != want.kind) begin
            errors++;
            $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
          end
          if (got.rom_address != want.rom_address) begin
            errors++;
            $display("%0t: rom_address expected %06h actual %06h",
                     $time, want.rom_address, got.rom_address);
          end
          if (got.read_data != want.read_data) begin
            errors++;
            $display("%0t: read_data expected %02h actual %02h",
                     $time, want.read_data, got.read_data);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, expected_q.size());
        $display("cartridge_bank_mapper_core test failed");
        $finish;
      end
    end
  end

  initial begin
    bit                wr;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic [6:0]        mask;

    plan_chk(FUNC_READ,  16'h0000, 8'h00, KIND_ROM,   21'h000000, 8'h00);
    plan_chk(FUNC_READ,  16'h7FFF, 8'h00, KIND_ROM,   21'h007FFF, 8'h00);
    plan_chk(FUNC_READ,  16'h4000, 8'h00, KIND_ROM,   21'h004000, 8'h00);
    plan_chk(FUNC_READ,  16'h8000, 8'h00, KIND_OPEN,  21'h000000, OPEN_BUS);
    plan_chk(FUNC_READ,  16'hA000, 8'h00, KIND_OPEN,  21'h000000, OPEN_BUS);
    plan_chk(FUNC_WRITE, 16'h0000, 8'h0A, KIND_WRITE, 21'h000000, 8'h00);
    plan_chk(FUNC_WRITE, 16'hA000, 8'h55, KIND_WRITE, 21'h000000, 8'h00);
    plan_chk(FUNC_READ,  16'hA000, 8'h00, KIND_OPEN,  21'h000000, OPEN_BUS);
    plan_io (FUNC_WRITE, 16'h2000, 8'h00);
    plan_io (FUNC_READ,  16'h4000, 8'h00);
    plan_chk(FUNC_WRITE, 16'hFFFF, 8'hFF, KIND_WRITE, 21'h000000, 8'h00);
    plan_chk(FUNC_READ,  16'hFFFF, 8'h00, KIND_OPEN,  21'h000000, OPEN_BUS);
    plan_reg(CFG_ROM_BANK_MASK, 7'd127);
    plan_reg(CFG_RAM_PRESENT, 7'd1);
    plan_reg(CFG_RAM_BANK_MASK, 7'd3);
    plan_io (FUNC_WRITE, 16'h1FFF, 8'h1A);
    plan_io (FUNC_WRITE, 16'h3FFF, 8'hFF);
    plan_io (FUNC_WRITE, 16'h5FFF, 8'hFF);
    plan_chk(FUNC_READ,  16'h7FFF, 8'h00, KIND_ROM,   21'h1FFFFF, 8'h00);
    plan_io (FUNC_WRITE, 16'h6000, MODE_ADVANCED);
    plan_chk(FUNC_READ,  16'h0000, 8'h00, KIND_ROM,   21'h180000, 8'h00);
    plan_io (FUNC_WRITE, 16'hBFFF, 8'hA5);
    plan_chk(FUNC_READ,  16'hBFFF, 8'h00, KIND_RAM,   21'h000000, 8'hA5);
    plan_io (FUNC_WRITE, 16'h7FFF, 8'h02);
    plan_io (FUNC_READ,  16'h3FFF, 8'h00);
    plan_io (FUNC_WRITE, 16'h0000, 8'h0B);
    plan_chk(FUNC_READ,  16'hBFFF, 8'h00, KIND_OPEN,  21'h000000, OPEN_BUS);
    plan_io (FUNC_WRITE, 16'h6000, MODE_SIMPLE);

    tx_idle_pct = 24;
    rx_idle_pct = 45;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_access(plan[i].wr, plan[i].addr, plan[i].data, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        tx_idle_pct = 45;
        rx_idle_pct = 24;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0: begin
          write_reg(CFG_ROM_BANK_MASK, 7'd1);
          write_reg(CFG_RAM_PRESENT, 7'd1);
          write_reg(CFG_RAM_BANK_MASK, 7'd0);
        end
        1: begin
          mask = (7'd1 << $urandom_range(1, 7)) - 7'd1;
          write_reg(CFG_ROM_BANK_MASK, mask);
          write_reg(CFG_RAM_PRESENT, 7'd1);
          write_reg(CFG_RAM_BANK_MASK, 7'd3);
        end
        2: begin
          write_reg(CFG_ROM_BANK_MASK, 7'($urandom_range(1, 127)));
          write_reg(CFG_RAM_PRESENT, 7'd0);
          write_reg(CFG_RAM_BANK_MASK, 7'($urandom_range(0, 3)));
        end
        3: begin
          write_reg(CFG_ROM_BANK_MASK, 7'd127);
          write_reg(CFG_RAM_PRESENT, 7'd1);
          write_reg(CFG_RAM_BANK_MASK, 7'd1);
        end
        4: begin
          write_reg(CFG_ROM_BANK_MASK, 7'($urandom_range(1, 127)));
          write_reg(CFG_RAM_PRESENT, 7'd1);
          write_reg(CFG_RAM_BANK_MASK, 7'd2);
        end
        default: begin
          write_reg(CFG_ROM_BANK_MASK, 7'd127);
          write_reg(CFG_RAM_PRESENT, 7'd1);
          write_reg(CFG_RAM_BANK_MASK, 7'd3);
        end
      endcase
      settings_used++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 80) settle();
        make_random_access(wr, a, d);
        send_access(wr, a, d, 1'b0, '0);
      end
    end

    settle();
    $display("Sent %0d bus accesses over %0d register settings and three idling patterns.",
             items_sent, settings_used);
    $display("Results: %0d ROM address, %0d RAM data, %0d open bus, %0d write done.",
             kind_seen[KIND_ROM], kind_seen[KIND_RAM], kind_seen[KIND_OPEN],
             kind_seen[KIND_WRITE]);
    if (errors == 0) begin
      $display("cartridge_bank_mapper_core test passed");
    end else begin
      $display("cartridge_bank_mapper_core test failed");
    end
    $finish;
  end

endmodule
